[rtl/core/pbp_pkg.sv]
// ----------------------------------------------------------------------------
// pbp_pkg: perceptron branch predictor shared definitions
// Field widths, operation and register codes, reset values and weight limits.
// ----------------------------------------------------------------------------
`default_nettype none

package pbp_pkg;

	// word field widths
	localparam int ADDR_W = 32;
	localparam int WT_W   = 8;
	localparam int SUM_W  = 13;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int THR_W      = 8;
	localparam int SHIFT_W    = 3;

	localparam logic [CFG_IDX_W-1:0] REG_TRAIN_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_SHIFT   = 1'b1;

	localparam logic [THR_W-1:0]   THR_RESET   = 8'd75;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd3;

	// operation codes
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	// saturation limits
	localparam int SUM_MIN = -4096;
	localparam int SUM_MAX = 4095;
	localparam int W_MIN   = -128;
	localparam int W_MAX   = 127;

endpackage

`default_nettype wire

[rtl/core/pbp_req_if.sv]
// ----------------------------------------------------------------------------
// pbp_req_if: request channel
// Valid/ready channel carrying one lookup or update word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbp_req_if;
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic [pbp_pkg::ADDR_W-1:0]  branch_address;
	logic                        outcome_taken;

	modport source (output valid, operation, branch_address, outcome_taken, input ready);
	modport sink   (input valid, operation, branch_address, outcome_taken, output ready);
endinterface

`default_nettype wire

[rtl/core/pbp_rsp_if.sv]
// ----------------------------------------------------------------------------
// pbp_rsp_if: response channel
// Valid/ready channel carrying one prediction or training result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbp_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              predict_taken;
	logic signed [pbp_pkg::SUM_W-1:0]  perceptron_sum;
	logic                              did_train;

	modport source (output valid, predict_taken, perceptron_sum, did_train, input ready);
	modport sink   (input valid, predict_taken, perceptron_sum, did_train, output ready);
endinterface

`default_nettype wire

[rtl/core/pbp_front.sv]
// ----------------------------------------------------------------------------
// pbp_front: request front end
// Accepts request words, shifts the address and reduces it modulo the
// table size by reciprocal multiplication, then hands a row-indexed item on.
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_front #(
	parameter int TABLE_ENTRIES = 256,
	localparam int RW = $clog2(TABLE_ENTRIES),
	localparam int ITEM_W = RW + 2
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	pbp_req_if.sink                           req,
	input  wire logic [pbp_pkg::SHIFT_W-1:0]  addr_shift,
	input  wire logic                         hold,
	output logic                              item_valid,
	output logic [ITEM_W-1:0]                 item,
	input  wire logic                         item_ready
);

	localparam int AW = pbp_pkg::ADDR_W;
	// floor(2^32 / N): the quotient estimate is exact or one short
	localparam logic [AW-1:0] RECIP = AW'((64'd1 << AW) / TABLE_ENTRIES);
	localparam logic [AW-1:0] DIVISOR = AW'(TABLE_ENTRIES);

	logic v_s1, v_s2, v_s3, v_s4;
	logic op_s1, op_s2, op_s3, op_s4;
	logic tk_s1, tk_s2, tk_s3, tk_s4;
	logic [AW-1:0] x_s1, x_s2, x_s3;
	logic [AW-1:0] quo_s2, qn_s3;
	logic [RW-1:0] row_s4;
	logic adv;
	logic [2*AW-1:0] prod;
	logic [AW-1:0] rem_raw, rem_fix;

	// whole pipe advances unless the last stage is blocked
	assign adv = !v_s4 || item_ready;
	assign req.ready = adv && !hold;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid && req.ready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// reduction arithmetic
	assign prod    = (2*AW)'(x_s1) * (2*AW)'(RECIP);
	assign rem_raw = x_s3 - qn_s3;
	assign rem_fix = (rem_raw >= DIVISOR) ? (rem_raw - DIVISOR) : rem_raw;

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= req.operation;
			tk_s1  <= req.outcome_taken;
			x_s1   <= req.branch_address >> addr_shift;

			op_s2  <= op_s1;
			tk_s2  <= tk_s1;
			x_s2   <= x_s1;
			quo_s2 <= prod[2*AW-1:AW];

			op_s3  <= op_s2;
			tk_s3  <= tk_s2;
			x_s3   <= x_s2;
			qn_s3  <= AW'(quo_s2 * DIVISOR);

			op_s4  <= op_s3;
			tk_s4  <= tk_s3;
			row_s4 <= rem_fix[RW-1:0];
		end
	end

	assign item_valid = v_s4;
	assign item       = {op_s4, tk_s4, row_s4};

endmodule

`default_nettype wire

[rtl/core/pbp_fifo.sv]
// ----------------------------------------------------------------------------
// pbp_fifo: two-entry item queue
// Decouples the front end from the back end so each can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_fifo #(
	parameter int W = 10
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire logic [W-1:0]  push_data,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output logic [W-1:0]       pop_data
);

	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   count_q;
	logic         push, pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

[rtl/core/pbp_back.sv]
// ----------------------------------------------------------------------------
// pbp_back: perceptron back end
// Holds the weight memory and global history, clears the memory after reset,
// sums a row through a registered two-level tree and trains rows on update.
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_back #(
	parameter int TABLE_ENTRIES = 256,
	parameter int HISTORY_LEN   = 32,
	localparam int RW = $clog2(TABLE_ENTRIES),
	localparam int ITEM_W = RW + 2
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       item_valid,
	output logic                            item_pop,
	input  wire logic [ITEM_W-1:0]          item,
	input  wire logic [pbp_pkg::THR_W-1:0]  train_threshold,
	output logic                            clearing,
	pbp_rsp_if.source                       rsp
);

	localparam int WB      = pbp_pkg::WT_W;
	localparam int SW      = pbp_pkg::SUM_W;
	localparam int ROW_W   = HISTORY_LEN * WB;
	localparam int GRP     = 8;
	localparam int NG      = (HISTORY_LEN + GRP - 1) / GRP;
	localparam int GRP_W   = WB + 2 + $clog2(GRP);
	localparam int ACC_RAW = WB + 2 + $clog2(HISTORY_LEN);
	localparam int ACC_W   = (ACC_RAW > SW) ? ACC_RAW : SW + 1;

	localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(pbp_pkg::SUM_MAX);
	localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(pbp_pkg::SUM_MIN);
	localparam logic signed [WB-1:0]    WT_MAX  = WB'(pbp_pkg::W_MAX);
	localparam logic signed [WB-1:0]    WT_MIN  = WB'(pbp_pkg::W_MIN);
	localparam logic [RW-1:0]           LAST_ROW = RW'(TABLE_ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SUM,
		ST_TOTAL,
		ST_TRAIN
	} state_t;

	state_t state_q;

	// weight memory, one row of HISTORY_LEN weights per entry
	logic [ROW_W-1:0] mem [TABLE_ENTRIES];
	logic [ROW_W-1:0] rd_row_q;
	logic [ROW_W-1:0] new_row;
	logic             mem_we;
	logic [RW-1:0]    mem_waddr;
	logic [ROW_W-1:0] mem_wdata;
	logic [RW-1:0]    rd_addr;

	logic [RW-1:0]           clr_cnt_q;
	logic [HISTORY_LEN-1:0]  hist_q;
	logic [RW-1:0]           last_row_q;
	logic signed [SW-1:0]    last_sum_q;
	logic [RW-1:0]           cur_row_q;
	logic                    taken_q;
	logic signed [GRP_W-1:0] grp_s1 [NG];
	logic signed [GRP_W-1:0] grp_sum [NG];
	logic signed [ACC_W-1:0] acc;
	logic signed [SW-1:0]    sum_sat;
	logic [SW-1:0]           mag;
	logic                    wrong, do_train;
	logic                    slot_free;
	logic                    rsp_load;

	logic          it_op, it_taken;
	logic [RW-1:0] it_row;

	assign it_op    = item[RW+1];
	assign it_taken = item[RW];
	assign it_row   = item[RW-1:0];

	assign clearing  = (state_q == ST_CLEAR);
	assign item_pop  = (state_q == ST_IDLE) && item_valid;
	assign slot_free = !rsp.valid || rsp.ready;
	assign rsp_load  = ((state_q == ST_TOTAL) || (state_q == ST_TRAIN)) && slot_free;
	assign rd_addr   = (it_op == pbp_pkg::OP_UPDATE) ? last_row_q : it_row;

	// group sums: weight 0 is always added as is; each other weight is taken as is or negated by its history bit
	always_comb begin
		int idx;
		logic signed [WB-1:0] w;
		logic signed [WB:0]   term;
		for (int g = 0; g < NG; g++) begin
			grp_sum[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				idx  = g * GRP + k;
				w    = '0;
				term = '0;
				if (idx < HISTORY_LEN) begin
					w    = rd_row_q[idx*WB +: WB];
					term = (idx == 0 || hist_q[idx]) ? (WB+1)'(w) : -((WB+1)'(w));
					grp_sum[g] = grp_sum[g] + GRP_W'(term);
				end
			end
		end
	end

	// final add and clamp
	always_comb begin
		acc = '0;
		for (int g = 0; g < NG; g++)
			acc = acc + ACC_W'(grp_s1[g]);
		if (acc > ACC_MAX)
			sum_sat = SW'(ACC_MAX);
		else if (acc < ACC_MIN)
			sum_sat = SW'(ACC_MIN);
		else
			sum_sat = SW'(acc);
	end

	// training decision and stepped row
	assign mag      = last_sum_q[SW-1] ? SW'(-last_sum_q) : SW'(last_sum_q);
	assign wrong    = (!last_sum_q[SW-1]) != taken_q;
	assign do_train = wrong || (mag <= SW'(train_threshold));

	always_comb begin
		logic signed [WB-1:0] w;
		logic                 inc;
		for (int i = 0; i < HISTORY_LEN; i++) begin
			w   = rd_row_q[i*WB +: WB];
			inc = (i == 0) ? taken_q : (hist_q[i] == taken_q);
			if (inc)
				new_row[i*WB +: WB] = (w == WT_MAX) ? w : w + WB'(1);
			else
				new_row[i*WB +: WB] = (w == WT_MIN) ? w : w - WB'(1);
		end
	end

	// memory write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_cnt_q;
		mem_wdata = '0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == ST_TRAIN && slot_free && do_train) begin
			mem_we    = 1'b1;
			mem_waddr = last_row_q;
			mem_wdata = new_row;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (item_pop)
			rd_row_q <= mem[rd_addr];
	end

	// group sum register
	always_ff @(posedge clk) begin
		if (state_q == ST_SUM)
			grp_s1 <= grp_sum;
	end

	// sequencer, history and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_CLEAR;
			clr_cnt_q          <= '0;
			hist_q             <= '1;
			last_row_q         <= '0;
			last_sum_q         <= '0;
			cur_row_q          <= '0;
			taken_q            <= 1'b0;
			rsp.valid          <= 1'b0;
			rsp.predict_taken  <= 1'b0;
			rsp.perceptron_sum <= '0;
			rsp.did_train      <= 1'b0;
		end else begin
			// result word offered until taken, reloaded as soon as the slot frees
			if (rsp_load)
				rsp.valid <= 1'b1;
			else if (rsp.valid && rsp.ready)
				rsp.valid <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + RW'(1);
					if (clr_cnt_q == LAST_ROW)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (item_valid) begin
						taken_q   <= it_taken;
						cur_row_q <= it_row;
						state_q   <= (it_op == pbp_pkg::OP_UPDATE) ? ST_TRAIN : ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_TOTAL;
				end
				ST_TOTAL: begin
					if (slot_free) begin
						rsp.predict_taken  <= !sum_sat[SW-1];
						rsp.perceptron_sum <= sum_sat;
						rsp.did_train      <= 1'b0;
						last_row_q         <= cur_row_q;
						last_sum_q         <= sum_sat;
						state_q            <= ST_IDLE;
					end
				end
				ST_TRAIN: begin
					if (slot_free) begin
						rsp.predict_taken  <= 1'b0;
						rsp.perceptron_sum <= '0;
						rsp.did_train      <= do_train;
						hist_q  <= {taken_q, hist_q[HISTORY_LEN-1:1]};
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/perceptron_branch_predictor_unit.sv]
// ----------------------------------------------------------------------------
// perceptron_branch_predictor_unit: global-history perceptron predictor
// Top level: configuration registers, front end, item queue and back end.
// ----------------------------------------------------------------------------
// After reset the block sweeps its weight memory to zero, one row a cycle;
// req.ready stays low during the sweep while configuration writes are taken as
// usual. A request word then passes a four-stage front end (address shift and
// reduction to a row index by reciprocal multiplication) and a two-entry queue
// into the back end, which works on one word at a time: a lookup goes through
// row read, registered group sums, and final add and clamp; an update through
// row read, saturating step and write-back. A finished result waits in its
// output register; the back end may start on the next word meanwhile but holds
// before loading that word's result until the register is taken.
`default_nettype none

module perceptron_branch_predictor_unit #(
	parameter int TABLE_ENTRIES = 256,
	parameter int HISTORY_LEN   = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	pbp_req_if.sink                              req,
	pbp_rsp_if.source                            rsp,
	input  wire logic                            cfg_we,
	input  wire logic [pbp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pbp_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int RW     = $clog2(TABLE_ENTRIES);
	localparam int ITEM_W = RW + 2;

	logic [pbp_pkg::THR_W-1:0]   thr_q;
	logic [pbp_pkg::SHIFT_W-1:0] shift_q;

	logic              f_valid, f_ready;
	logic [ITEM_W-1:0] f_item;
	logic              q_valid, q_pop;
	logic [ITEM_W-1:0] q_item;
	logic              clearing;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= pbp_pkg::THR_RESET;
			shift_q <= pbp_pkg::SHIFT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pbp_pkg::REG_TRAIN_THRESHOLD: thr_q   <= cfg_data[pbp_pkg::THR_W-1:0];
				pbp_pkg::REG_ADDRESS_SHIFT:   shift_q <= cfg_data[pbp_pkg::SHIFT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pbp_front #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.addr_shift (shift_q),
		.hold       (clearing),
		.item_valid (f_valid),
		.item       (f_item),
		.item_ready (f_ready)
	);

	pbp_fifo #(
		.W (ITEM_W)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_pop),
		.pop_data   (q_item)
	);

	pbp_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.HISTORY_LEN   (HISTORY_LEN)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (q_valid),
		.item_pop        (q_pop),
		.item            (q_item),
		.train_threshold (thr_q),
		.clearing        (clearing),
		.rsp             (rsp)
	);

endmodule

`default_nettype wire

[rtl/core/pbp_checker.sv]
// ----------------------------------------------------------------------------
// pbp_checker: port-level checks for the predictor
// Tracks outstanding words and checks result hold, spurious results and capacity.
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready
);

	// front stages, queue, back end and output register
	localparam logic [3:0] CAPACITY = 4'd8;

	logic [3:0] outstanding_q;
	logic       req_fire, rsp_fire;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	// words accepted and not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			outstanding_q <= 4'd0;
		else if (req_fire && !rsp_fire)
			outstanding_q <= outstanding_q + 4'd1;
		else if (rsp_fire && !req_fire)
			outstanding_q <= outstanding_q - 4'd1;
	end

	// a stalled result stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result word withdrawn while stalled");

	// no result without an accepted request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> outstanding_q != 4'd0)
		else $error("result word with no request outstanding");

	// the block never holds more words than it has places for
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= CAPACITY)
		else $error("more words in flight than storage allows");

endmodule

bind perceptron_branch_predictor_unit pbp_checker u_pbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready)
);

`default_nettype wire
